// File: hw/rtl/ising_metropolis_spin_update_macros.svh
// Assertion helpers for the checker file of the spin update block.
`ifndef ISING_METROPOLIS_SPIN_UPDATE_MACROS_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define IMSU_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define IMSU_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define IMSU_ASSERT_NXT_NORST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/imsu_pkg.sv
package imsu_pkg;

    // Channel and register port widths
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 80;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 64;

    // Field widths
    localparam int ROW_W    = 6;
    localparam int FRAC_W   = 32;
    localparam int THR_W    = 33;
    localparam int ENERGY_W = 15;
    localparam int MAG_W    = 14;
    localparam int COUNT_W  = 48;

    localparam logic [THR_W-1:0]   THR_RESET = {1'b1, {(THR_W-1){1'b0}}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Item kinds
    localparam logic OP_FLIP  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register select, taken from the 64-bit word address bit
    localparam logic REG_THR_DE4 = 1'b0;
    localparam logic REG_THR_DE8 = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } imsu_state_t;

    // Port enables of the row store
    typedef struct packed {
        logic wr_en;
        logic rd_a_en;
        logic rd_b_en;
    } imsu_ram_ctl_t;

endpackage

// File: hw/rtl/imsu_row_ram.sv
// Lattice row store: one write port, two read ports, registered read data.
module imsu_row_ram
    import imsu_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  imsu_ram_ctl_t    ctl,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_a_addr,
    output logic [WIDTH-1:0] rd_a_data,
    input  logic [AW-1:0]    rd_b_addr,
    output logic [WIDTH-1:0] rd_b_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read ports hold their data when not enabled
    always_ff @(posedge aclk) begin
        if (ctl.rd_a_en) begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (ctl.rd_b_en) begin
            rd_b_reg <= mem[rd_b_addr];
        end
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

// File: hw/rtl/ising_metropolis_spin_update.sv
// Channel   Dir  Handshake           Contents
// s_        in   s_tvalid/s_tready   site, random fraction, spin; kind in s_tuser
// m_        out  m_tvalid/m_tready   accepted flag, energy, magnetization, count
// APB       in   psel/penable        flip thresholds for dE = 4 and dE = 8
//
// An item passes through three steps: accept (rows r and r-1 read), read of
// row r+1, evaluate and write back row r; the next item may be accepted in the
// cycle after. The two read ports of the row store set this sequence.
// After reset a clearing pass writes every row, filling the lattice with +1; no
// item is accepted meanwhile. A waiting result holds the evaluate step only.
module ising_metropolis_spin_update
    import imsu_pkg::*;
#(
    parameter int SIDE = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // row[5:0], col[11:6], random_fraction[43:12], spin_value[44], zero fill
    input  logic [S_DATA_W-1:0]   s_tdata,
    // opcode[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // accepted[0], total_energy[15:1], total_magnetization[29:16],
    // accepted_count[77:30], zero fill
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int RW    = (SIDE > 2) ? $clog2(SIDE) : 1;
    localparam int CELLS = SIDE * SIDE;
    localparam logic [RW-1:0]       LAST_IDX   = RW'(SIDE - 1);
    localparam logic [ENERGY_W-1:0] ENERGY_RST = ENERGY_W'(-2 * CELLS);
    localparam logic [MAG_W-1:0]    MAG_RST    = MAG_W'(CELLS);

    imsu_state_t state_reg, state_next;

    // configuration
    logic [THR_W-1:0] thr4_reg;
    logic [THR_W-1:0] thr8_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr4_reg <= THR_RESET;
            thr8_reg <= THR_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3])
                REG_THR_DE4: thr4_reg <= pwdata[THR_W-1:0];
                REG_THR_DE8: thr8_reg <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            REG_THR_DE4: prdata = CFG_DATA_W'(thr4_reg);
            REG_THR_DE8: prdata = CFG_DATA_W'(thr8_reg);
            default:     prdata = '0;
        endcase
    end

    // input fields
    logic [ROW_W-1:0]  in_row;
    logic [ROW_W-1:0]  in_col;
    logic [RW-1:0]     in_ridx;
    logic [RW-1:0]     in_cidx;
    logic [RW-1:0]     in_rp;
    logic [RW-1:0]     in_rm;
    logic              in_range;
    logic              s_fire;

    assign in_row   = s_tdata[5:0];
    assign in_col   = s_tdata[11:6];
    assign in_ridx  = RW'(in_row);
    assign in_cidx  = RW'(in_col);
    assign in_range = (32'(in_row) < SIDE) && (32'(in_col) < SIDE);
    assign in_rp    = (in_ridx == LAST_IDX) ? '0 : in_ridx + RW'(1);
    assign in_rm    = (in_ridx == '0) ? LAST_IDX : in_ridx - RW'(1);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // item held while it is worked on
    logic              op_reg;
    logic [RW-1:0]     ridx_reg;
    logic [RW-1:0]     cidx_reg;
    logic [RW-1:0]     rp_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic              spin_reg;
    logic              inr_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg   <= s_tuser;
            ridx_reg <= in_ridx;
            cidx_reg <= in_cidx;
            rp_reg   <= in_rp;
            frac_reg <= s_tdata[43:12];
            spin_reg <= s_tdata[44];
            inr_reg  <= in_range;
        end
    end

    // row store
    imsu_ram_ctl_t   ram_ctl;
    logic [RW-1:0]   wr_addr;
    logic [SIDE-1:0] wr_data;
    logic [RW-1:0]   rd_b_addr;
    logic [SIDE-1:0] row_c;
    logic [SIDE-1:0] row_d;
    logic [SIDE-1:0] up_reg;
    logic [RW-1:0]   clr_cnt_reg;
    logic            clearing;
    logic            eval_go;
    logic            changed;
    logic [SIDE-1:0] new_row;

    assign clearing  = (state_reg == ST_CLEAR);
    assign eval_go   = (state_reg == ST_EVAL) && (!m_tvalid || m_tready);
    assign rd_b_addr = (state_reg == ST_READ) ? rp_reg : in_rm;
    assign wr_addr   = clearing ? clr_cnt_reg : ridx_reg;
    assign wr_data   = clearing ? '1 : new_row;

    always_comb begin
        ram_ctl.wr_en   = clearing || (eval_go && changed);
        ram_ctl.rd_a_en = s_fire;
        ram_ctl.rd_b_en = s_fire || (state_reg == ST_READ);
    end

    imsu_row_ram #(
        .DEPTH (SIDE),
        .WIDTH (SIDE),
        .AW    (RW)
    ) u_row_ram (
        .aclk      (aclk),
        .ctl       (ram_ctl),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (in_ridx),
        .rd_a_data (row_c),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (row_d)
    );

    // row above is parked while port B fetches the row below
    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            up_reg <= row_d;
        end
    end

    // neighbour sum and energy change
    logic [RW-1:0]       cp;
    logic [RW-1:0]       cm;
    logic                s_bit;
    logic [2:0]          k_up;
    logic signed [4:0]   nb;
    logic signed [4:0]   nb2;
    logic signed [4:0]   de;
    logic                flip_ok;
    logic                accepted;
    logic                new_bit;

    assign cp    = (cidx_reg == LAST_IDX) ? '0 : cidx_reg + RW'(1);
    assign cm    = (cidx_reg == '0) ? LAST_IDX : cidx_reg - RW'(1);
    assign s_bit = row_c[cidx_reg];
    assign k_up  = 3'(row_c[cm]) + 3'(row_c[cp]) + 3'(up_reg[cidx_reg])
                 + 3'(row_d[cidx_reg]);
    // sum of four +/-1 neighbours is twice the up count less four
    assign nb    = $signed({1'b0, k_up, 1'b0}) - 5'sd4;
    assign nb2   = nb <<< 1;
    assign de    = s_bit ? nb2 : -nb2;

    always_comb begin
        if (de[4] || (de == 5'sd0)) begin
            flip_ok = 1'b1;
        end else if (de == 5'sd4) begin
            flip_ok = ({1'b0, frac_reg} <= thr4_reg);
        end else begin
            flip_ok = ({1'b0, frac_reg} <= thr8_reg);
        end
    end

    assign accepted = inr_reg && ((op_reg == OP_WRITE) || flip_ok);
    assign new_bit  = (op_reg == OP_WRITE) ? spin_reg : ~s_bit;
    assign changed  = accepted && (new_bit != s_bit);

    always_comb begin
        new_row           = row_c;
        new_row[cidx_reg] = new_bit;
    end

    // running totals
    logic signed [ENERGY_W-1:0] energy_reg, energy_next;
    logic signed [MAG_W-1:0]    mag_reg, mag_next;
    logic [COUNT_W-1:0]         count_reg, count_next;

    always_comb begin
        energy_next = energy_reg;
        mag_next    = mag_reg;
        count_next  = count_reg;
        if (changed) begin
            energy_next = energy_reg + ENERGY_W'(de);
            mag_next    = mag_reg + (s_bit ? -MAG_W'(2) : MAG_W'(2));
        end
        if (accepted && (op_reg == OP_FLIP) && (count_reg != COUNT_MAX)) begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_reg <= ENERGY_RST;
            mag_reg    <= MAG_RST;
            count_reg  <= '0;
        end else if (eval_go) begin
            energy_reg <= energy_next;
            mag_reg    <= mag_next;
            count_reg  <= count_next;
        end
    end

    // result register
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (eval_go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eval_go) begin
            m_tdata_reg <= {2'b00, count_next, mag_next, energy_next, accepted};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // clearing pass counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (clearing) begin
            clr_cnt_reg <= clr_cnt_reg + RW'(1);
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (eval_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

endmodule

// File: hw/rtl/imsu_checker.sv
`include "ising_metropolis_spin_update_macros.svh"

// Port-level checks for the spin update block.
module imsu_checker
    import imsu_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata
);

    // reset leaves no result and no ready while the lattice is cleared
    `IMSU_ASSERT_NXT_NORST(a_reset_quiet, aclk, !aresetn, !m_tvalid && !s_tready, "reset not quiet")

    // a stalled result holds
    `IMSU_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")

    // one item in flight: no accept in the cycle after an accept
    `IMSU_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "item accepted while busy")

    // every accepted item is followed by a result on the port
    `IMSU_ASSERT_IMP(a_result_due, aclk, aresetn, s_tvalid && s_tready, ##3 m_tvalid, "result missing")

endmodule

bind ising_metropolis_spin_update imsu_checker u_imsu_checker (.*);
